### rtl/spq_pkg.sv
// Shared types, widths and codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int VALUE_W = 32;
   localparam int PRIO_W = 16;
   localparam int OCC_W = 5;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USED_W = VALUE_W + PRIO_W + OCC_W;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] item_value;
      logic [PRIO_W-1:0]  item_priority;
   } cell_type;

   typedef struct packed {
      logic               insert;
      logic               remove;
      logic [VALUE_W-1:0] item_value;
      logic [PRIO_W-1:0]  item_priority;
   } op_type;

endpackage

`default_nettype wire

### rtl/spq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
`default_nettype none

module spq_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire spq_pkg::op_type   op,
   input  wire spq_pkg::cell_type left_cell,
   input  wire logic              left_hold,
   input  wire spq_pkg::cell_type right_cell,
   output spq_pkg::cell_type      cell_state,
   output logic                   cell_hold
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [spq_pkg::VALUE_W-1:0] value_ff;
   logic [spq_pkg::VALUE_W-1:0] value_in;
   logic [spq_pkg::PRIO_W-1:0]  prio_ff;
   logic [spq_pkg::PRIO_W-1:0]  prio_in;

   assign cell_hold = valid_ff && (prio_ff <= op.item_priority);

   always_comb begin
      priority if (op.remove) begin
         valid_in = right_cell.valid;
         value_in = right_cell.item_value;
         prio_in  = right_cell.item_priority;
      end else if (op.insert && !cell_hold) begin
         if (left_hold) begin
            valid_in = 1'b1;
            value_in = op.item_value;
            prio_in  = op.item_priority;
         end else begin
            valid_in = left_cell.valid;
            value_in = left_cell.item_value;
            prio_in  = left_cell.item_priority;
         end
      end else begin
         valid_in = valid_ff;
         value_in = value_ff;
         prio_in  = prio_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign cell_state = '{valid: valid_ff, item_value: value_ff, item_priority: prio_ff};

endmodule

`default_nettype wire

### rtl/sorted_priority_queue.sv
// Sorted priority queue: a row of cells kept in ascending priority order.
`default_nettype none

// Bounded queue of value and priority pairs; a lower priority number leaves first and
// equal priorities leave in arrival order. Each request word is an insert or a remove;
// every word yields exactly one response word, valid in the cycle after it is accepted. All cells
// compare the new priority against their own entry and shift left or right in the same
// cycle, so one word is taken per clock; only a stalled response slows the input. An
// insert into a full queue answers overflow, a remove from an empty queue underflow,
// both leaving the queue unchanged. Occupancy carries the low 5 bits of the entry count.
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [31:0] item_value, [47:32] item_priority
   input  wire logic [spq_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] command
   input  wire logic                           req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [31:0] out_value, [47:32] out_priority, [52:48] occupancy, [55:53] zero
   output logic [spq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] status
   output logic [spq_pkg::STATUS_W-1:0]        rsp_tuser
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   spq_pkg::cell_type cells [CAPACITY];
   logic              holds [CAPACITY];
   spq_pkg::op_type   op;

   logic                          accept;
   logic                          is_remove;
   logic                          full;
   logic                          empty;
   spq_pkg::status_type           status;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [spq_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [spq_pkg::RSP_DATA_W-1:0] rsp_data_in;
   logic [spq_pkg::STATUS_W-1:0]  rsp_user_ff;
   logic [spq_pkg::STATUS_W-1:0]  rsp_user_in;
   logic [spq_pkg::VALUE_W-1:0]   out_value;
   logic [spq_pkg::PRIO_W-1:0]    out_prio;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_remove  = (req_tuser == spq_pkg::CMD_REMOVE);
   assign full       = cells[CAPACITY-1].valid;
   assign empty      = !cells[0].valid;

   assign op.insert        = accept && !is_remove && !full;
   assign op.remove        = accept && is_remove && !empty;
   assign op.item_value    = req_tdata[spq_pkg::VALUE_W-1:0];
   assign op.item_priority = req_tdata[spq_pkg::VALUE_W +: spq_pkg::PRIO_W];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_pkg::cell_type left_cell;
      spq_pkg::cell_type right_cell;
      logic              left_hold;

      if (i == 0) begin : g_head
         assign left_cell = '{valid: 1'b1, item_value: '0, item_priority: '0};
         assign left_hold = 1'b1;
      end else begin : g_body
         assign left_cell = cells[i-1];
         assign left_hold = holds[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_cell = '{valid: 1'b0, item_value: '0, item_priority: '0};
      end else begin : g_mid
         assign right_cell = cells[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .left_cell  (left_cell),
         .left_hold  (left_hold),
         .right_cell (right_cell),
         .cell_state (cells[i]),
         .cell_hold  (holds[i])
      );
   end

   always_comb begin
      priority if (op.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (op.remove) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      status   = spq_pkg::STATUS_OK;
      out_value = '0;
      out_prio  = '0;
      if (is_remove) begin
         if (empty) begin
            status = spq_pkg::STATUS_UNDERFLOW;
         end else begin
            out_value = cells[0].item_value;
            out_prio  = cells[0].item_priority;
         end
      end else if (full) begin
         status = spq_pkg::STATUS_OVERFLOW;
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      priority if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = spq_pkg::RSP_DATA_W'({spq_pkg::OCC_W'(count_in), out_prio, out_value});
         rsp_user_in  = status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

### rtl/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
`default_nettype none

module spq_checker #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [spq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [spq_pkg::STATUS_W-1:0]   rsp_tuser
);

   logic [spq_pkg::VALUE_W-1:0] out_value;
   logic [spq_pkg::PRIO_W-1:0]  out_prio;
   logic [spq_pkg::OCC_W-1:0]   occupancy;

   assign out_value = rsp_tdata[spq_pkg::VALUE_W-1:0];
   assign out_prio  = rsp_tdata[spq_pkg::VALUE_W +: spq_pkg::PRIO_W];
   assign occupancy = rsp_tdata[spq_pkg::VALUE_W + spq_pkg::PRIO_W +: spq_pkg::OCC_W];

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while response slot is free");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != spq_pkg::STATUS_OK |-> out_value == '0 && out_prio == '0)
      else $error("error response carries data");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == spq_pkg::STATUS_UNDERFLOW |-> occupancy == '0)
      else $error("underflow reported with entries held");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 31) || (32'(occupancy) <= 32'(CAPACITY)))
      else $error("occupancy above capacity");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

`default_nettype wire
